### rtl/rglg_pkg.sv
package rglg_pkg;

    // Default size of the node table.
    localparam int NODES_DEFAULT = 16;

    // Field widths of one request and one result.
    localparam int CMD_W      = 1;
    localparam int ROLE_W     = 2;
    localparam int NODE_FW    = 8;
    localparam int IDX_W      = 4;
    localparam int ERR_W      = 3;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 8;

    // Request kinds carried in tuser.
    localparam logic [CMD_W-1:0] CMD_ADD     = 1'b0;
    localparam logic [CMD_W-1:0] CMD_CONNECT = 1'b1;

    // Node roles.
    typedef enum logic [ROLE_W-1:0] {
        ROLE_OTHER  = 2'd0,
        ROLE_CLICK  = 2'd1,
        ROLE_GUIDE  = 2'd2,
        ROLE_MASTER = 2'd3
    } t_role;

    // Result codes.
    typedef enum logic [ERR_W-1:0] {
        ERR_NONE     = 3'd0,
        ERR_ENDPOINT = 3'd1,
        ERR_SELF     = 3'd2,
        ERR_SAFE     = 3'd3,
        ERR_LOOP     = 3'd4,
        ERR_FULL     = 3'd5
    } t_err;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic add_node;
        logic read_dst;
        logic capture_src_role;
        logic walk_init;
        logic walk_step;
        logic set_edge;
        logic res_load;
        t_err res_err;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_connect;
        logic full;
        logic bad_endpoint;
        logic self_route;
        logic safe_mode;
        logic found;
        logic next_empty;
    } t_dp_sts;

endpackage

### rtl/rglg_ram.sv
module rglg_ram import rglg_pkg::*; #(
    parameter int WIDTH = ROLE_W,
    parameter int DEPTH = NODES_DEFAULT
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/rglg_datapath.sv
module rglg_datapath import rglg_pkg::*; #(
    parameter int NODES = NODES_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic [CMD_W-1:0]      i_command,
    input  logic [ROLE_W-1:0]     i_role,
    input  logic [NODE_FW-1:0]    i_from_node,
    input  logic [NODE_FW-1:0]    i_to_node,
    output logic [OUT_DATA_W-1:0] o_out_data
);

    localparam int AW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);

    // Captured request.
    logic [CMD_W-1:0]   r_command;
    logic [ROLE_W-1:0]  r_role;
    logic [NODE_FW-1:0] r_src;
    logic [NODE_FW-1:0] r_dst;
    logic [ROLE_W-1:0]  r_src_role;

    // Graph state.
    logic [CW-1:0]    r_count;
    logic [NODES-1:0] r_adj [NODES];
    logic [NODES-1:0] r_visited;
    logic [NODES-1:0] r_frontier;

    // Pending result and output register.
    logic              r_res_ok;
    logic [IDX_W-1:0]  r_res_idx;
    t_err              r_res_err;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [AW-1:0]     src_idx;
    logic [AW-1:0]     dst_idx;
    logic [AW-1:0]     ram_raddr;
    logic [ROLE_W-1:0] ram_rdata;
    logic [NODES-1:0]  n_reach;
    logic [NODES-1:0]  n_next;

    assign src_idx   = r_src[AW-1:0];
    assign dst_idx   = r_dst[AW-1:0];
    assign ram_raddr = i_cmd.read_dst ? dst_idx : src_idx;

    // Role table, written by add and read once per endpoint of a connect.
    rglg_ram #(
        .WIDTH (ROLE_W),
        .DEPTH (NODES)
    ) u_role_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.add_node),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_role),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // One breadth-first step: union of the rows of the frontier nodes.
    always_comb begin
        n_reach = '0;
        for (int n = 0; n < NODES; n++) begin
            if (r_frontier[n]) begin
                n_reach = n_reach | r_adj[n];
            end
        end
        n_next = n_reach & ~r_visited;
    end

    // Status toward the controller.
    always_comb begin
        o_sts.is_connect   = (r_command == CMD_CONNECT);
        o_sts.full         = (r_count == CW'(NODES));
        o_sts.bad_endpoint = (r_src >= NODE_FW'(r_count)) || (r_dst >= NODE_FW'(r_count));
        o_sts.self_route   = (r_src == r_dst);
        o_sts.safe_mode    = ((r_src_role == ROLE_CLICK) || (r_src_role == ROLE_GUIDE)) &&
                             (ram_rdata == ROLE_MASTER);
        o_sts.found        = r_frontier[src_idx];
        o_sts.next_empty   = (n_next == '0);
    end

    // Request capture and role holding; payload only.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_command <= i_command;
            r_role    <= i_role;
            r_src     <= i_from_node;
            r_dst     <= i_to_node;
        end
        if (i_cmd.capture_src_role) begin
            r_src_role <= ram_rdata;
        end
    end

    // Node count, routes and the walk sets.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_visited  <= '0;
            r_frontier <= '0;
            for (int n = 0; n < NODES; n++) begin
                r_adj[n] <= '0;
            end
        end else begin
            if (i_cmd.add_node) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.set_edge) begin
                r_adj[src_idx][dst_idx] <= 1'b1;
            end
            if (i_cmd.walk_init) begin
                r_visited  <= NODES'(1) << dst_idx;
                r_frontier <= NODES'(1) << dst_idx;
            end else if (i_cmd.walk_step) begin
                r_visited  <= r_visited | n_next;
                r_frontier <= n_next;
            end
        end
    end

    // Result and output registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res_err <= i_cmd.res_err;
            r_res_ok  <= (i_cmd.res_err == ERR_NONE);
            r_res_idx <= i_cmd.add_node ? IDX_W'(r_count) : '0;
        end
        if (i_cmd.load_out) begin
            r_out_data <= {r_res_err, r_res_idx, r_res_ok};
        end
    end

    assign o_out_data = r_out_data;

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(NODES))
        else $error("node count above table size");

    a_edge_not_self : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.set_edge |-> (src_idx != dst_idx))
        else $error("self route written");

    a_frontier_visited : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_frontier & ~r_visited) == '0)
        else $error("frontier node not marked visited");

endmodule

### rtl/rglg_ctrl.sv
module rglg_ctrl import rglg_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_RDDST = 6'b000100,
        S_ROLE  = 6'b001000,
        S_WALK  = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_valid;
    logic   n_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_valid;

    // Sequencing of one request through checks, role reads and the walk.
    always_comb begin
        o_cmd         = '0;
        o_cmd.res_err = ERR_NONE;
        n_state       = r_state;
        n_valid       = r_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!i_sts.is_connect) begin
                    o_cmd.res_load = 1'b1;
                    if (i_sts.full) begin
                        o_cmd.res_err = ERR_FULL;
                    end else begin
                        o_cmd.add_node = 1'b1;
                    end
                    n_state = S_FIN;
                end else if (i_sts.bad_endpoint) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_err  = ERR_ENDPOINT;
                    n_state        = S_FIN;
                end else if (i_sts.self_route) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_err  = ERR_SELF;
                    n_state        = S_FIN;
                end else begin
                    n_state = S_RDDST;
                end
            end
            S_RDDST: begin
                o_cmd.read_dst         = 1'b1;
                o_cmd.capture_src_role = 1'b1;
                n_state                = S_ROLE;
            end
            S_ROLE: begin
                if (i_sts.safe_mode) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_err  = ERR_SAFE;
                    n_state        = S_FIN;
                end else begin
                    o_cmd.walk_init = 1'b1;
                    n_state         = S_WALK;
                end
            end
            S_WALK: begin
                if (i_sts.found) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_err  = ERR_LOOP;
                    n_state        = S_FIN;
                end else if (i_sts.next_empty) begin
                    o_cmd.set_edge = 1'b1;
                    o_cmd.res_load = 1'b1;
                    n_state        = S_FIN;
                end else begin
                    o_cmd.walk_step = 1'b1;
                end
            end
            S_FIN: begin
                if (!r_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_valid        = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and output valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    a_valid_from_fin : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_valid) |-> $past(r_state == S_FIN))
        else $error("result shown without a finished request");

    a_loop_ends : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && i_sts.found) |=> (r_state == S_FIN))
        else $error("walk continued after reaching the source");

    a_accept_exec : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_EXEC))
        else $error("accepted request not executed");

endmodule

### rtl/route_graph_loop_guard.sv
// Route table with loop guard. Nodes are appended by add requests (tuser 0), which return
// the new index or table full; connect requests (tuser 1) are checked for a bad endpoint, a
// self route, a click or guide node routed to a master node, and finally for a loop by a
// breadth-first walk from the destination along existing routes, one frontier step per cycle.
// One request is handled at a time. An add, or a connect refused by an endpoint or self
// check, passes from acceptance in S_IDLE through S_EXEC to S_FIN, where it waits for room
// on the output; a safe-mode refusal also passes S_RDDST and S_ROLE, and a connect that
// reaches the walk stays in S_WALK for each frontier step. The role table is read through a
// single port, one endpoint per cycle. A new request is taken while a result still waits on
// the output. No clearing pass follows reset; routes and the node count are cleared at once.
module route_graph_loop_guard import rglg_pkg::*; #(
    parameter int NODES = NODES_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // tdata: role[1:0], from_node[9:2], to_node[17:10], zero fill[23:18]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: command[0]
    input  logic [CMD_W-1:0]      s_axis_tuser,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: ok[0], node_index[4:1], error_code[7:5]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    rglg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (dp_cmd),
        .i_sts       (dp_sts)
    );

    rglg_datapath #(
        .NODES (NODES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_command   (s_axis_tuser),
        .i_role      (s_axis_tdata[1:0]),
        .i_from_node (s_axis_tdata[9:2]),
        .i_to_node   (s_axis_tdata[17:10]),
        .o_out_data  (m_axis_tdata)
    );

endmodule

### dv/route_graph_loop_guard_tb.sv
`timescale 1ns / 100ps

module route_graph_loop_guard_tb;
    import rglg_pkg::*;

    localparam int NODES        = NODES_DEFAULT;
    localparam int CLK_HALF     = 6;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 800;
    localparam int SETTLE_WAIT  = 2 * (NODES + 5);
    localparam int DIR_N        = 26;
    localparam int FILL_W       = IN_DATA_W - 2 * NODE_FW - ROLE_W;
    localparam int REPORT_MAX   = 10;

    // One result as seen on the master side.
    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] idx;
        t_err             err;
    } t_route_result;

    // One row of the directed table; fixed rows carry their own expected result.
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        t_role              role;
        logic [NODE_FW-1:0] from_node;
        logic [NODE_FW-1:0] to_node;
        logic               fixed;
        t_route_result      result;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [CMD_W-1:0]      s_axis_tuser  = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;

    // Shadow copy of the node table and the route matrix.
    int unsigned           node_total = 0;
    t_role                 node_roles [NODES];
    logic [NODES-1:0]      route_rows [NODES];

    t_route_result         pending_results [$];
    t_dir_row              directed_rows [DIR_N];
    int                    mismatches      = 0;
    int                    results_checked = 0;
    int                    requests_sent   = 0;
    int                    err_tally [8];
    bit                    idle_free       = 1'b0;
    int                    cycles          = 0;

    route_graph_loop_guard #(
        .NODES(NODES)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Breadth-first walk along the routes from start; true if target is reached.
    function automatic bit walk_reaches(int start, int target);
        logic [NODES-1:0] seen;
        logic [NODES-1:0] front;
        logic [NODES-1:0] nxt;
        seen        = '0;
        seen[start] = 1'b1;
        front       = seen;
        for (int step = 0; step < NODES; step++) begin
            if (front[target]) return 1'b1;
            nxt = '0;
            for (int n = 0; n < NODES; n++) begin
                if (front[n]) nxt |= route_rows[n];
            end
            nxt   &= ~seen;
            seen  |= nxt;
            front  = nxt;
            if (nxt == '0) return 1'b0;
        end
        return front[target];
    endfunction

    // Applies one request to the shadow table and returns the result it should give.
    function automatic t_route_result apply_route_request(logic [CMD_W-1:0] cmd, t_role role,
                                                          int src, int dst);
        t_route_result res;
        res = '{1'b0, '0, ERR_NONE};
        if (cmd == CMD_ADD) begin
            if (node_total >= NODES) begin
                res.err = ERR_FULL;
            end else begin
                node_roles[node_total] = role;
                res.ok  = 1'b1;
                res.idx = IDX_W'(node_total);
                node_total++;
            end
        end else if (src >= node_total || dst >= node_total) begin
            res.err = ERR_ENDPOINT;
        end else if (src == dst) begin
            res.err = ERR_SELF;
        end else if ((node_roles[src] == ROLE_CLICK || node_roles[src] == ROLE_GUIDE) &&
                     node_roles[dst] == ROLE_MASTER) begin
            res.err = ERR_SAFE;
        end else if (walk_reaches(dst, src)) begin
            res.err = ERR_LOOP;
        end else begin
            route_rows[src][dst] = 1'b1;
            res.ok = 1'b1;
        end
        return res;
    endfunction

    // Presents one request after a random gap and records its expected result on acceptance.
    // Valid stays high after the request so that back-to-back requests need no toggle.
    task automatic send_request(logic [CMD_W-1:0] cmd, t_role role, logic [NODE_FW-1:0] src,
                                logic [NODE_FW-1:0] dst, bit fixed, t_route_result typed);
        int            gap;
        t_route_result predicted;
        t_route_result queued;
        gap = idle_free ? 0 : $urandom_range(4, 0);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= {{FILL_W{1'b0}}, dst, src, role};
        s_axis_tuser  <= cmd;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (s_axis_tready !== 1'b1) @(posedge i_clk);
        predicted = apply_route_request(cmd, role, int'(src), int'(dst));
        queued    = fixed ? typed : predicted;
        pending_results.insert(pending_results.size(), queued);
        err_tally[predicted.err]++;
        requests_sent++;
    endtask

    // Holds the sender off until every outstanding result has been taken.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Result side: random stalls on tready, and a field-by-field check of each result.
    initial begin : result_sink
        int            stall;
        t_route_result want;
        logic          got_ok;
        logic [IDX_W-1:0] got_idx;
        logic [ERR_W-1:0] got_err;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = idle_free ? 0 : $urandom_range(4, 0);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (m_axis_tvalid !== 1'b1) @(posedge i_clk);
            got_ok  = m_axis_tdata[0];
            got_idx = m_axis_tdata[4:1];
            got_err = m_axis_tdata[7:5];
            results_checked++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("ERROR: unexpected result ok=%0d idx=%0d err=%0d",
                             got_ok, got_idx, got_err);
            end else begin
                want = pending_results.pop_front();
                if (got_ok !== want.ok || got_idx !== want.idx || got_err !== want.err) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display({"ERROR: result %0d expected ok=%0d idx=%0d err=%0d, ",
                                  "got ok=%0d idx=%0d err=%0d"},
                                 results_checked, want.ok, want.idx, want.err,
                                 got_ok, got_idx, got_err);
                end
            end
        end
    end

    // Cycle limit for a hung block.
    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // Request side: reset, directed table, then random requests.
    initial begin : stimulus
        int            pick;
        int            a;
        int            b;
        t_dir_row      row;
        t_route_result no_result;
        no_result = '{1'b0, '0, ERR_NONE};
        for (int n = 0; n < NODES; n++) begin
            node_roles[n] = ROLE_OTHER;
            route_rows[n] = '0;
        end
        for (int e = 0; e < 8; e++) err_tally[e] = 0;

        directed_rows = '{
            // Connect on an empty table: both endpoints are out of range.
            '{CMD_CONNECT, ROLE_OTHER,  8'd0,  8'd0,  1'b1, '{1'b0, 4'd0,  ERR_ENDPOINT}},
            // One node of each role; endpoint fields of an add are ignored.
            '{CMD_ADD,     ROLE_OTHER,  8'hFF, 8'hFF, 1'b1, '{1'b1, 4'd0,  ERR_NONE}},
            '{CMD_ADD,     ROLE_CLICK,  8'd0,  8'd0,  1'b1, '{1'b1, 4'd1,  ERR_NONE}},
            '{CMD_ADD,     ROLE_GUIDE,  8'd0,  8'd0,  1'b1, '{1'b1, 4'd2,  ERR_NONE}},
            '{CMD_ADD,     ROLE_MASTER, 8'h55, 8'hAA, 1'b1, '{1'b1, 4'd3,  ERR_NONE}},
            // Click and guide nodes may not feed a master.
            '{CMD_CONNECT, ROLE_OTHER,  8'd1,  8'd3,  1'b1, '{1'b0, 4'd0,  ERR_SAFE}},
            '{CMD_CONNECT, ROLE_OTHER,  8'd2,  8'd3,  1'b1, '{1'b0, 4'd0,  ERR_SAFE}},
            // Self route; the role field of a connect is ignored.
            '{CMD_CONNECT, ROLE_MASTER, 8'd0,  8'd0,  1'b1, '{1'b0, 4'd0,  ERR_SELF}},
            // A forward route, its reverse closing a loop, and a master feeding another node.
            '{CMD_CONNECT, ROLE_OTHER,  8'd0,  8'd1,  1'b0, '{1'b0, 4'd0,  ERR_NONE}},
            '{CMD_CONNECT, ROLE_OTHER,  8'd1,  8'd0,  1'b0, '{1'b0, 4'd0,  ERR_NONE}},
            '{CMD_CONNECT, ROLE_CLICK,  8'd3,  8'd0,  1'b0, '{1'b0, 4'd0,  ERR_NONE}},
            // Endpoint equal to the node count, and one at the top of the field.
            '{CMD_CONNECT, ROLE_OTHER,  8'd4,  8'd0,  1'b1, '{1'b0, 4'd0,  ERR_ENDPOINT}},
            '{CMD_CONNECT, ROLE_OTHER,  8'd0,  8'hFF, 1'b1, '{1'b0, 4'd0,  ERR_ENDPOINT}},
            // Fill the rest of the table, mostly plain nodes so long chains can form.
            '{CMD_ADD,     ROLE_OTHER,  8'd0,  8'd0,  1'b1, '{1'b1, 4'd4,  ERR_NONE}},
            '{CMD_ADD,     ROLE_OTHER,  8'd0,  8'd0,  1'b1, '{1'b1, 4'd5,  ERR_NONE}},
            '{CMD_ADD,     ROLE_CLICK,  8'd0,  8'd0,  1'b1, '{1'b1, 4'd6,  ERR_NONE}},
            '{CMD_ADD,     ROLE_OTHER,  8'd0,  8'd0,  1'b1, '{1'b1, 4'd7,  ERR_NONE}},
            '{CMD_ADD,     ROLE_OTHER,  8'd0,  8'd0,  1'b1, '{1'b1, 4'd8,  ERR_NONE}},
            '{CMD_ADD,     ROLE_GUIDE,  8'd0,  8'd0,  1'b1, '{1'b1, 4'd9,  ERR_NONE}},
            '{CMD_ADD,     ROLE_OTHER,  8'd0,  8'd0,  1'b1, '{1'b1, 4'd10, ERR_NONE}},
            '{CMD_ADD,     ROLE_OTHER,  8'd0,  8'd0,  1'b1, '{1'b1, 4'd11, ERR_NONE}},
            '{CMD_ADD,     ROLE_OTHER,  8'd0,  8'd0,  1'b1, '{1'b1, 4'd12, ERR_NONE}},
            '{CMD_ADD,     ROLE_MASTER, 8'd0,  8'd0,  1'b1, '{1'b1, 4'd13, ERR_NONE}},
            '{CMD_ADD,     ROLE_OTHER,  8'd0,  8'd0,  1'b1, '{1'b1, 4'd14, ERR_NONE}},
            '{CMD_ADD,     ROLE_OTHER,  8'hFF, 8'd0,  1'b1, '{1'b1, 4'd15, ERR_NONE}},
            // One more add finds the table full.
            '{CMD_ADD,     ROLE_GUIDE,  8'd0,  8'd0,  1'b1, '{1'b0, 4'd0,  ERR_FULL}}
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            send_request(row.cmd, row.role, row.from_node, row.to_node, row.fixed, row.result);
        end
        drain_results();

        // Mostly in-range connects, a share of them short forward hops that build chains
        // for deep walks; the rest are adds on a full table, self routes and wild endpoints.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            idle_free = ((i / 50) % 4) == 3;
            if (i == RANDOM_ITEMS / 2) drain_results();
            pick = $urandom_range(99, 0);
            if (pick < 5) begin
                a = $urandom_range(255, 0);
                b = $urandom_range(255, 0);
                send_request(CMD_ADD, t_role'($urandom_range(3, 0)), NODE_FW'(a), NODE_FW'(b),
                             1'b0, no_result);
            end else if (pick < 15) begin
                a = $urandom_range(255, 0);
                b = $urandom_range(255, 0);
                send_request(CMD_CONNECT, t_role'($urandom_range(3, 0)), NODE_FW'(a),
                             NODE_FW'(b), 1'b0, no_result);
            end else if (pick < 20) begin
                a = $urandom_range(NODES - 1, 0);
                send_request(CMD_CONNECT, t_role'($urandom_range(3, 0)), NODE_FW'(a),
                             NODE_FW'(a), 1'b0, no_result);
            end else if (pick < 55) begin
                a = $urandom_range(NODES - 2, 0);
                b = a + $urandom_range(3, 1);
                if (b > NODES - 1) b = NODES - 1;
                send_request(CMD_CONNECT, t_role'($urandom_range(3, 0)), NODE_FW'(a),
                             NODE_FW'(b), 1'b0, no_result);
            end else begin
                a = $urandom_range(NODES - 1, 0);
                b = $urandom_range(NODES - 1, 0);
                send_request(CMD_CONNECT, t_role'($urandom_range(3, 0)), NODE_FW'(a),
                             NODE_FW'(b), 1'b0, no_result);
            end
        end

        drain_results();
        repeat (SETTLE_WAIT) @(posedge i_clk);

        $display("summary: %0d requests sent, %0d results checked, %0d accepted",
                 requests_sent, results_checked, err_tally[ERR_NONE]);
        $display("summary: refused for endpoint %0d, self %0d, safe mode %0d, loop %0d, full %0d",
                 err_tally[ERR_ENDPOINT], err_tally[ERR_SELF], err_tally[ERR_SAFE],
                 err_tally[ERR_LOOP], err_tally[ERR_FULL]);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
